// ----- rtl/k_way_sorted_merge_top_macros.svh -----
// Assertion macros for the verification files of the merge block.
// Depends on nothing; included by the port checker.
`ifndef K_WAY_SORTED_MERGE_TOP_MACROS_SVH
`define K_WAY_SORTED_MERGE_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define KWM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset.
`define KWM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/kwm_pkg.sv -----
// Shared types and codes for the k-way sorted merge block.
// Depends on nothing; imported by every module of the block but kwm_ram.
`default_nettype none

package kwm_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes of a result beat.
  localparam logic [2:0] ST_VALUE    = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_APPENDED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // Width of the value fields on the ports.
  localparam int VALUE_FIELD_W = 16;

  typedef struct packed {
    logic [1:0]          op;
    logic [3:0]          lane;
    logic signed [15:0]  value;
  } kwm_in_t;

  typedef struct packed {
    logic signed [15:0]  merged_value;
    logic [2:0]          status;
  } kwm_out_t;

  // Commands from the sequencer to the lane pointer table.
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } kwm_lane_cmd_t;

  // Commands from the sequencer to the shared minimum unit.
  typedef struct packed {
    logic init;
    logic issue;
    logic nonempty;
  } kwm_cmp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/kwm_ram.sv -----
// Generic simple dual-port RAM with a registered read.
// Depends on nothing; holds the lane values of the merge block.
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/kwm_lanes.sv -----
// Read pointer and fill count of every lane FIFO, accessed at one selected lane.
// Depends on kwm_pkg for the command struct.
`default_nettype none

module kwm_lanes #(
  parameter int LANES = 16,
  parameter int LANE_DEPTH = 256,
  localparam int LW = $clog2(LANES),
  localparam int SW = $clog2(LANE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kwm_pkg::kwm_lane_cmd_t cmd,
  input  logic [LW-1:0]          sel,
  output logic [SW-1:0]          head,
  output logic [SW-1:0]          tail,
  output logic                   full,
  output logic                   empty
);
  import kwm_pkg::*;

  localparam int CW = $clog2(LANE_DEPTH + 1);
  localparam int AW = SW + 1;

  logic [CW-1:0] cnt [LANES];
  logic [SW-1:0] hd  [LANES];
  logic [CW-1:0] cnt_sel;
  logic [AW-1:0] sum;
  logic [SW-1:0] head_inc;

  // Everything reads the one selected lane.
  assign cnt_sel = cnt[sel];
  assign head    = hd[sel];
  assign full    = (cnt_sel == CW'(LANE_DEPTH));
  assign empty   = (cnt_sel == '0);

  // Tail slot: head plus count, wrapped once around the lane depth.
  assign sum  = AW'(head) + AW'(cnt_sel);
  assign tail = (sum >= AW'(LANE_DEPTH)) ? SW'(sum - AW'(LANE_DEPTH)) : sum[SW-1:0];

  assign head_inc = (head == SW'(LANE_DEPTH - 1)) ? '0 : head + 1'b1;

  // Pointer update; clear empties every lane at once.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      for (int i = 0; i < LANES; i++) begin
        cnt[i] <= '0;
        hd[i]  <= '0;
      end
    end else if (cmd.push) begin
      cnt[sel] <= cnt_sel + 1'b1;
    end else if (cmd.pop) begin
      cnt[sel] <= cnt_sel - 1'b1;
      hd[sel]  <= head_inc;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kwm_min.sv -----
// Shared comparator that keeps the smallest lane head seen during a scan.
// Depends on kwm_pkg for the command struct.
`default_nettype none

module kwm_min #(
  parameter int LANES = 16,
  parameter int VALUE_WIDTH = 16,
  localparam int LW = $clog2(LANES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kwm_pkg::kwm_cmp_cmd_t  cmd,
  input  logic [LW-1:0]          lane,
  input  logic [VALUE_WIDTH-1:0] rdata,
  output logic                   found,
  output logic [LW-1:0]          best_lane,
  output logic [VALUE_WIDTH-1:0] best_val
);
  import kwm_pkg::*;

  logic          p_valid;
  logic          p_ne;
  logic [LW-1:0] p_lane;
  logic          better;

  // Strictly less keeps the lowest lane on equal heads.
  assign better = !found || ($signed(rdata) < $signed(best_val));

  // The issue is registered, like the lane tag, to meet the registered RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
      if (cmd.init) begin
        found <= 1'b0;
      end else if (p_valid && p_ne && better) begin
        found <= 1'b1;
      end
    end
  end

  // Payload of the pipeline stage and the running minimum.
  always_ff @(posedge clk) begin
    p_ne   <= cmd.nonempty;
    p_lane <= lane;
    if (!cmd.init && p_valid && p_ne && better) begin
      best_lane <= p_lane;
      best_val  <= rdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/k_way_sorted_merge_top.sv -----
// Take: sel steps through every lane in S_SCAN while the shared comparator reads and
// compares one lane head per cycle; after S_DRAIN and S_PICK, done rises as S_COMMIT ends
// (as S_PICK ends if every lane is empty). Append: done rises as S_APPEND ends; clear and
// an out-of-range append raise it at the accepting edge, one per cycle. Busy is high
// until then and low while a result is shown, so the next beat may follow; the receiver
// cannot stall. Synchronous reset empties every lane at once; no clearing pass.
`default_nettype none

module k_way_sorted_merge_top #(
  parameter int LANES = 16,
  parameter int LANE_DEPTH = 256,
  parameter int VALUE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kwm_pkg::kwm_in_t  item,
  output logic              done,
  output kwm_pkg::kwm_out_t result
);
  import kwm_pkg::*;

  localparam int LW = $clog2(LANES);
  localparam int SW = $clog2(LANE_DEPTH);
  localparam int RAM_DEPTH = LANES * (2 ** SW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0]             state;
  logic [LW-1:0]          sel;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] wval;
  logic [VALUE_FIELD_W-1:0] out_val;
  logic                   lane_ok;

  kwm_lane_cmd_t          lcmd;
  kwm_cmp_cmd_t           ccmd;
  logic [SW-1:0]          head;
  logic [SW-1:0]          tail;
  logic                   full;
  logic                   empty;
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   found;
  logic [LW-1:0]          best_lane;
  logic [VALUE_WIDTH-1:0] best_val;

  assign busy    = (state != S_IDLE);
  assign lane_ok = (int'(item.lane) < LANES);

  // Width adaption between the port fields and the stored values.
  if (VALUE_WIDTH > VALUE_FIELD_W) begin : g_wide
    assign wval    = {{(VALUE_WIDTH - VALUE_FIELD_W){1'b0}}, item.value};
    assign out_val = best_val[VALUE_FIELD_W-1:0];
  end else if (VALUE_WIDTH == VALUE_FIELD_W) begin : g_same
    assign wval    = item.value;
    assign out_val = best_val;
  end else begin : g_narrow
    assign wval    = item.value[VALUE_WIDTH-1:0];
    assign out_val = {{(VALUE_FIELD_W - VALUE_WIDTH){1'b0}}, best_val};
  end

  // Commands to the lane table and the comparator.
  always_comb begin
    lcmd.clr      = (state == S_IDLE) && start && (item.op == OP_CLEAR);
    lcmd.push     = (state == S_APPEND) && !full;
    lcmd.pop      = (state == S_COMMIT);
    ccmd.init     = (state == S_IDLE);
    ccmd.issue    = (state == S_SCAN);
    ccmd.nonempty = !empty;
  end

  kwm_lanes #(
    .LANES      (LANES),
    .LANE_DEPTH (LANE_DEPTH)
  ) u_lanes (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lcmd),
    .sel   (sel),
    .head  (head),
    .tail  (tail),
    .full  (full),
    .empty (empty)
  );

  kwm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (lcmd.push),
    .waddr ({sel, tail}),
    .wdata (val_q),
    .raddr ({sel, head}),
    .rdata (rdata)
  );

  kwm_min #(
    .LANES       (LANES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_min (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ccmd),
    .lane      (sel),
    .rdata     (rdata),
    .found     (found),
    .best_lane (best_lane),
    .best_val  (best_val)
  );

  // Sequencer control state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      sel   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (item.op)
              OP_APPEND: begin
                if (lane_ok) begin
                  sel   <= LW'(item.lane);
                  state <= S_APPEND;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_TAKE: begin
                sel   <= '0;
                state <= S_SCAN;
              end
              OP_CLEAR: begin
                done <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_APPEND: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (sel == LW'(LANES - 1)) begin
            state <= S_DRAIN;
          end else begin
            sel <= sel + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (found) begin
            sel   <= best_lane;
            state <= S_COMMIT;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_COMMIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload and the latched append value.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        val_q               <= wval;
        result.merged_value <= '0;
        result.status       <= (item.op == OP_CLEAR) ? ST_CLEARED : ST_FULL;
      end
      S_APPEND: begin
        result.merged_value <= '0;
        result.status       <= full ? ST_FULL : ST_APPENDED;
      end
      S_PICK: begin
        result.merged_value <= '0;
        result.status       <= ST_EMPTY;
      end
      S_COMMIT: begin
        result.merged_value <= out_val;
        result.status       <= ST_VALUE;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/kwm_chk.sv -----
// Port-level checker for the merge block, bound to the top level.
// Depends on kwm_pkg and k_way_sorted_merge_top_macros.svh.
`default_nettype none
`include "k_way_sorted_merge_top_macros.svh"

module kwm_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input kwm_pkg::kwm_in_t  item,
  input logic              done,
  input kwm_pkg::kwm_out_t result
);
  import kwm_pkg::*;

  // Reset leaves the block idle with no beat on the result side.
  `KWM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")

  // Only a delivered value carries a non-zero merged value.
  `KWM_ASSERT(a_zero_value, clk, rst, (done && (result.status != ST_VALUE)) |-> (result.merged_value == '0), "merged value not zero")

  // A take always starts a scan, so the block is busy after accepting it.
  `KWM_ASSERT(a_take_busy, clk, rst, (start && !busy && (item.op == OP_TAKE)) |=> busy, "take did not start a scan")

  // Every item that raises busy ends with a result beat.
  `KWM_ASSERT(a_end_beat, clk, rst, $fell(busy) |-> done, "busy ended without a result")

  // The unused operation code gives no beat and no work.
  `KWM_ASSERT(a_unused_op, clk, rst, (start && !busy && (item.op != OP_APPEND) && (item.op != OP_TAKE) && (item.op != OP_CLEAR)) |=> (!done && !busy), "unused op produced activity")

endmodule

bind k_way_sorted_merge_top kwm_chk u_kwm_chk (.*);

`default_nettype wire

// ----- dv/tb_k_way_sorted_merge_top.sv -----
// Self-checking testbench for the k-way sorted merge block (start/busy command side,
// done strobe on the result side). Depends on kwm_pkg and k_way_sorted_merge_top only;
// expected results come from a lane model kept inside this file.
`default_nettype none

module tb_k_way_sorted_merge_top;
  import kwm_pkg::*;

  localparam int NUM_LANES    = 16;
  localparam int DEPTH        = 256;
  localparam int ITEM_TARGET  = 1600;
  localparam int SETTLE_ABOVE = NUM_LANES + 8;

  // The one op code that the package leaves unnamed; the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  kwm_in_t  item = '0;
  logic     done;
  kwm_out_t result;

  k_way_sorted_merge_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Beats waiting to be driven, and merge results that the block still owes.
  kwm_in_t  beats_pending[$];
  kwm_out_t merge_results_due[$];
  int       mismatches = 0;

  // Lane model: a circular buffer per lane with a read pointer and a fill count.
  logic signed [15:0] lane_vals [NUM_LANES][DEPTH];
  logic [7:0]         lane_rd   [NUM_LANES] = '{default: '0};
  logic [8:0]         lane_fill [NUM_LANES] = '{default: '0};

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("MISMATCH %s: expected %0d, got %0d", what, want_v, got_v);
    mismatches++;
  endtask

  // Apply one accepted beat to the lane model and queue the result it must produce.
  task automatic merge_lanes_step(input kwm_in_t beat);
    kwm_out_t           outcome;
    logic [7:0]         slot;
    logic signed [15:0] best_val;
    int                 best_lane;
    outcome = '0;
    best_val = '0;
    best_lane = -1;
    case (beat.op)
      OP_APPEND: begin
        if (lane_fill[beat.lane] >= DEPTH) begin
          outcome.status = ST_FULL;
        end else begin
          slot = lane_rd[beat.lane] + lane_fill[beat.lane][7:0];
          lane_vals[beat.lane][slot] = beat.value;
          lane_fill[beat.lane]++;
          outcome.status = ST_APPENDED;
        end
      end
      OP_TAKE: begin
        // Strict less-than keeps the lowest-indexed lane on equal heads.
        for (int l = 0; l < NUM_LANES; l++) begin
          if (lane_fill[l] != 0) begin
            if (best_lane < 0 || lane_vals[l][lane_rd[l]] < best_val) begin
              best_lane = l;
              best_val = lane_vals[l][lane_rd[l]];
            end
          end
        end
        if (best_lane < 0) begin
          outcome.status = ST_EMPTY;
        end else begin
          lane_rd[best_lane]++;
          lane_fill[best_lane]--;
          outcome.merged_value = best_val;
          outcome.status = ST_VALUE;
        end
      end
      OP_CLEAR: begin
        for (int l = 0; l < NUM_LANES; l++) begin
          lane_rd[l] = '0;
          lane_fill[l] = '0;
        end
        outcome.status = ST_CLEARED;
      end
      default: return;
    endcase
    merge_results_due.push_back(outcome);
  endtask

  // Driver: bursts of back-to-back beats separated by random idle gaps.
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    logic fire;
    int   r;
    fire = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (fire) begin
        merge_lanes_step(item);
        burst_left--;
        if (burst_left <= 0) begin
          r = $urandom_range(0, 9);
          if (r < 3) begin
            gap_left = 0;
          end else if (r < 8) begin
            gap_left = $urandom_range(1, 5);
          end else begin
            gap_left = $urandom_range(6, 40);
          end
          burst_left = $urandom_range(1, 40);
        end
      end
      // A beat not yet taken stays on the port unchanged.
      if (!(start && !fire)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (beats_pending.size() != 0) begin
          start <= 1'b1;
          item <= beats_pending.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest one owed.
  always @(posedge clk) begin
    kwm_out_t want;
    if (!rst && done) begin
      if (merge_results_due.size() == 0) begin
        report_mismatch("unexpected result, status", -1, int'(result.status));
      end else begin
        want = merge_results_due.pop_front();
        if (result.merged_value !== want.merged_value) begin
          report_mismatch("merged_value", int'(want.merged_value), int'(result.merged_value));
        end
        if (result.status !== want.status) begin
          report_mismatch("status", int'(want.status), int'(result.status));
        end
      end
    end
  end

  // Stimulus bookkeeping: the ignored op code does not count as an item.
  int issued = 0;

  task automatic queue_beat(input logic [1:0] op, input int lane, input int value);
    kwm_in_t beat;
    beat.op = op;
    beat.lane = lane[3:0];
    beat.value = value[15:0];
    beats_pending.push_back(beat);
    if (op != OP_UNUSED) issued++;
  endtask

  // Fill one lane past its depth, drain part of it, then refill so the pointers wrap.
  task automatic fill_lane_round();
    int l;
    int v;
    l = $urandom_range(0, NUM_LANES - 1);
    v = -32768 + $urandom_range(0, 100);
    for (int i = 0; i < DEPTH + 6; i++) begin
      queue_beat(OP_APPEND, l, v);
      v += $urandom_range(0, 3);
    end
    for (int i = $urandom_range(30, 60); i > 0; i--) queue_beat(OP_TAKE, 0, 0);
    for (int i = 0; i < 40; i++) begin
      queue_beat(OP_APPEND, l, v);
      v += $urandom_range(0, 3);
    end
    for (int i = 0; i < 20; i++) queue_beat(OP_TAKE, 0, 0);
    if ($urandom_range(0, 1) == 0) queue_beat(OP_CLEAR, 0, 0);
  endtask

  // A round of ascending runs on random lanes, with ties and the odd unsorted value,
  // followed by enough takes to run the lanes dry now and then.
  int seq_last [NUM_LANES];

  task automatic merge_round();
    int n_app;
    int l;
    int r;
    int v;
    int shared_v;
    n_app = $urandom_range(4, 60);
    shared_v = int'($signed(16'($urandom())));
    if ($urandom_range(0, 9) < 3) begin
      for (int i = 0; i < NUM_LANES; i++) seq_last[i] = -32768 + $urandom_range(0, 2000);
    end
    for (int i = 0; i < n_app; i++) begin
      r = $urandom_range(0, 99);
      l = $urandom_range(0, NUM_LANES - 1);
      if (r < 20) begin
        queue_beat(OP_TAKE, $urandom_range(0, 15), int'(16'($urandom())));
      end else if (r < 26) begin
        queue_beat(OP_APPEND, l, int'(16'($urandom())));
      end else if (r < 32) begin
        queue_beat(OP_APPEND, l, shared_v);
      end else begin
        v = seq_last[l] + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600));
        if (v > 32767) v = 32767;
        seq_last[l] = v;
        queue_beat(OP_APPEND, l, v);
      end
    end
    for (int i = $urandom_range(1, n_app + 6); i > 0; i--) queue_beat(OP_TAKE, 0, 0);
    if ($urandom_range(0, 9) == 0) queue_beat(OP_CLEAR, $urandom_range(0, 15), 0);
    if ($urandom_range(0, 19) == 0) begin
      queue_beat(OP_UNUSED, $urandom_range(0, 15), int'(16'($urandom())));
    end
  endtask

  initial begin : run_merge_test
    int fills_done;
    fills_done = 0;
    for (int i = 0; i < NUM_LANES; i++) seq_last[i] = -32768 + $urandom_range(0, 4000);

    // Directed opening: empty take, value extremes, a tie, unsorted appends,
    // the ignored op code and a clear with data still held.
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_APPEND, 0, -32768);
    queue_beat(OP_APPEND, 15, 32767);
    queue_beat(OP_APPEND, 9, -32768);
    queue_beat(OP_APPEND, 5, 0);
    queue_beat(OP_APPEND, 3, 21845);
    queue_beat(OP_APPEND, 12, -21846);
    queue_beat(OP_APPEND, 5, -100);
    queue_beat(OP_UNUSED, 10, 32767);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_APPEND, 0, 7);
    queue_beat(OP_CLEAR, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_APPEND, 1, -1);
    queue_beat(OP_APPEND, 2, -1);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_UNUSED, 5, -1);

    // Random part; two rounds drive a lane to overflow and wrap its pointers.
    while (issued < ITEM_TARGET) begin
      if (fills_done < 2 && issued > (fills_done + 1) * 450) begin
        fill_lane_round();
        fills_done++;
      end else begin
        merge_round();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (beats_pending.size() != 0 || start || merge_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_ABOVE) @(posedge clk);

    if (mismatches == 0 && merge_results_due.size() == 0) begin
      $display("** k_way_sorted_merge_top: PASSED **");
    end else begin
      $display("** k_way_sorted_merge_top: FAILED **");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #4000000;
    $display("** k_way_sorted_merge_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
